>>> rtl/tcf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcf_pkg: shared constants for the tilt complementary filter
// Register indexes, command codes and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package tcf_pkg;

	localparam int CordicSteps = 16;
	localparam int IterW = 5;

	localparam logic [2:0] REG_SAMPLE_PERIOD = 3'd0;
	localparam logic [2:0] REG_GYRO_BLEND    = 3'd1;
	localparam logic [2:0] REG_RATE_SCALE    = 3'd2;
	localparam logic [2:0] REG_BIAS_RATE     = 3'd3;
	localparam logic [2:0] REG_BIAS_WINDOW   = 3'd4;

	localparam logic CMD_UPDATE = 1'b0;
	localparam logic CMD_SEED   = 1'b1;

	// arctangent of 2^-i in 1/65536 degree
	function automatic logic signed [23:0] atan_lut(input logic [IterW-1:0] i);
		logic signed [23:0] r;
		begin
			case (i)
				5'd0: r = 24'sd2949120;
				5'd1: r = 24'sd1740967;
				5'd2: r = 24'sd919879;
				5'd3: r = 24'sd466945;
				5'd4: r = 24'sd234379;
				5'd5: r = 24'sd117304;
				5'd6: r = 24'sd58666;
				5'd7: r = 24'sd29335;
				5'd8: r = 24'sd14668;
				5'd9: r = 24'sd7334;
				5'd10: r = 24'sd3667;
				5'd11: r = 24'sd1833;
				5'd12: r = 24'sd917;
				5'd13: r = 24'sd458;
				5'd14: r = 24'sd229;
				5'd15: r = 24'sd115;
				5'd16: r = 24'sd57;
				5'd17: r = 24'sd29;
				5'd18: r = 24'sd14;
				5'd19: r = 24'sd7;
				5'd20: r = 24'sd4;
				5'd21: r = 24'sd2;
				5'd22: r = 24'sd1;
				default: r = 24'sd0;
			endcase
			return r;
		end
	endfunction

endpackage
`default_nettype wire

>>> rtl/tcf_cordic.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcf_cordic: iterative atan2 in 1/65536 degree
// One micro-rotation per cycle through a shared shift-add unit.
// ----------------------------------------------------------------------------
module tcf_cordic (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic signed [15:0] ay,
	input  wire logic signed [15:0] az,
	output logic                    done,
	output logic signed [31:0]      tilt
);
	logic signed [33:0] x_q, y_q;
	logic signed [31:0] z_q;
	logic [tcf_pkg::IterW-1:0] i_q;
	logic busy_q;
	logic signed [33:0] xs, ys, x0, y0;
	logic signed [31:0] z0;
	logic zero_in;

	assign xs = x_q >>> i_q;
	assign ys = y_q >>> i_q;
	assign zero_in = (ay == 16'sd0) && (az == 16'sd0);

	// pre-rotation by 180 degrees for a negative z axis
	always_comb begin
		x0 = 34'(az) <<< 14;
		y0 = 34'(ay) <<< 14;
		z0 = '0;
		if (az < 0) begin
			z0 = (ay >= 0) ? 32'sd11796480 : -32'sd11796480;
			x0 = -x0;
			y0 = -y0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			i_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				x_q <= x0;
				y_q <= y0;
				z_q <= z0;
				i_q <= '0;
				if (zero_in) begin
					z_q <= '0;
					done <= 1'b1;
				end else begin
					busy_q <= 1'b1;
				end
			end else if (busy_q) begin
				if (y_q >= 0) begin
					x_q <= x_q + ys;
					y_q <= y_q - xs;
					z_q <= z_q + 32'(tcf_pkg::atan_lut(i_q));
				end else begin
					x_q <= x_q - ys;
					y_q <= y_q + xs;
					z_q <= z_q - 32'(tcf_pkg::atan_lut(i_q));
				end
				i_q <= i_q + 1'b1;
				if (i_q == tcf_pkg::IterW'(tcf_pkg::CordicSteps - 1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	assign tilt = z_q;
endmodule
`default_nettype wire

>>> rtl/tcf_mac.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tcf_mac: shared 34x18 signed multiplier with registered product
// Used in turn by every multiply of the filter update.
// ----------------------------------------------------------------------------
module tcf_mac (
	input  wire logic               clk,
	input  wire logic signed [33:0] a,
	input  wire logic signed [17:0] b,
	output logic signed [51:0]      p
);
	always_ff @(posedge clk) begin
		p <= a * b;
	end
endmodule
`default_nettype wire

>>> rtl/tilt_complementary_filter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tilt_complementary_filter: complementary tilt filter with gyro bias tracking
// Top level: handshakes, registers, sequencer and state.
// ----------------------------------------------------------------------------
// Usage: an input item (command, accel_y, accel_z, gyro_x) is accepted when
// in_valid is high and in_stall low. in_stall stays high from acceptance until
// the result has been taken. The block runs the CORDIC tilt (CordicSteps
// micro-rotations, skipped for an all-zero accelerometer vector); a seed then
// takes that tilt as angle and gyro_x as bias, an update runs seven products
// on one shared registered multiplier. Both load the outputs in ST_OUT. The
// result (tilt_angle, bias_estimate) holds with out_valid high while out_stall
// is high; the next item can be accepted in the cycle after the result is
// taken. The CORDIC loop and the single multiplier set how long an item takes.
// Configuration registers are written through cfg_valid/cfg_ready with
// cfg_index and cfg_data; the user must write them only while idle, as the
// block itself does not enforce it. cfg_ready is always high. Reset clears
// angle and bias to zero and loads register defaults.
// ----------------------------------------------------------------------------
module tilt_complementary_filter (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic               command,
	input  wire logic signed [15:0] accel_y,
	input  wire logic signed [15:0] accel_z,
	input  wire logic signed [15:0] gyro_x,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic signed [15:0]      tilt_angle,
	output logic signed [15:0]      bias_estimate,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [15:0]        cfg_data
);
	typedef enum logic [3:0] {
		ST_IDLE, ST_CORDIC, ST_RATEL, ST_RATEH, ST_STEP, ST_MIXA, ST_MIXB,
		ST_BIASL, ST_BIASH, ST_OUT
	} state_t;

	state_t state_q;
	logic phase_q;
	logic [15:0] period_q, blend_q, scale_q, brate_q;
	logic [9:0] window_q;
	logic cmd_q;
	logic signed [15:0] gx_q;
	logic signed [31:0] angle_q;
	logic signed [47:0] bias_q;
	logic signed [63:0] tmp_q;
	logic signed [33:0] mac_a;
	logic signed [17:0] mac_b;
	logic signed [51:0] mac_p;
	logic cordic_done;
	logic signed [31:0] tilt;
	logic in_acc;
	logic signed [47:0] gx24, win, lo, hi, corr;
	logic signed [47:0] d_val, bd_val;
	logic signed [63:0] mix_r;
	logic signed [40:0] ta_r;
	logic signed [24:0] be_r;

	assign in_acc = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;

	tcf_cordic u_cordic (
		.clk(clk), .arst_n(arst_n), .start(in_acc), .ay(accel_y), .az(accel_z),
		.done(cordic_done), .tilt(tilt)
	);

	tcf_mac u_mac (.clk(clk), .a(mac_a), .b(mac_b), .p(mac_p));

	// clamped bias correction value
	always_comb begin
		gx24 = 48'(gx_q) <<< 24;
		win = 48'({window_q, 24'd0});
		lo = bias_q - win;
		hi = bias_q + win;
		corr = gx24;
		if (corr < lo) corr = lo;
		if (corr > hi) corr = hi;
		if (corr < -48'sd549755813888) corr = -48'sd549755813888;
		if (corr > 48'sd549739036672) corr = 48'sd549739036672;
	end

	// gyro step and bias error, each multiplied as a low 24-bit and a high part
	assign d_val = gx24 - bias_q;
	assign bd_val = corr - bias_q;

	// multiplier operand selection
	always_comb begin
		mac_a = '0;
		mac_b = '0;
		case (state_q)
			ST_RATEL: begin
				mac_a = $signed({10'd0, d_val[23:0]});
				mac_b = 18'($signed({1'b0, scale_q}));
			end
			ST_RATEH: begin
				mac_a = 34'(d_val >>> 24);
				mac_b = 18'($signed({1'b0, scale_q}));
			end
			ST_STEP: begin
				mac_a = tmp_q[33:0];
				mac_b = 18'($signed({1'b0, period_q}));
			end
			ST_MIXA: begin
				mac_a = tmp_q[33:0];
				mac_b = 18'($signed({1'b0, blend_q}));
			end
			ST_MIXB: begin
				mac_a = 34'(tilt);
				mac_b = 18'sd65536 - 18'($signed({1'b0, blend_q}));
			end
			ST_BIASL: begin
				mac_a = $signed({10'd0, bd_val[23:0]});
				mac_b = 18'($signed({1'b0, brate_q}));
			end
			ST_BIASH: begin
				mac_a = 34'(bd_val >>> 24);
				mac_b = 18'($signed({1'b0, brate_q}));
			end
			default: ;
		endcase
	end

	// rounded blend of the two angle paths
	assign mix_r = (tmp_q + 64'(mac_p) + 64'sd32768) >>> 16;

	assign ta_r = (41'(angle_q) + 41'sd256) >>> 9;
	assign be_r = 25'((bias_q + 48'sd8388608) >>> 24);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= 1'b0;
			out_valid <= 1'b0;
			period_q <= 16'd655;
			blend_q <= 16'd64881;
			scale_q <= 16'd1001;
			brate_q <= 16'd8389;
			window_q <= 10'd10;
			angle_q <= '0;
			bias_q <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					tcf_pkg::REG_SAMPLE_PERIOD: period_q <= cfg_data;
					tcf_pkg::REG_GYRO_BLEND: blend_q <= cfg_data;
					tcf_pkg::REG_RATE_SCALE: scale_q <= cfg_data;
					tcf_pkg::REG_BIAS_RATE: brate_q <= cfg_data;
					tcf_pkg::REG_BIAS_WINDOW: window_q <= cfg_data[9:0];
					default: ;
				endcase
			end
			case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						cmd_q <= command;
						gx_q <= gyro_x;
						state_q <= ST_CORDIC;
					end
				end
				ST_CORDIC: begin
					if (cordic_done) begin
						phase_q <= 1'b0;
						if (cmd_q == tcf_pkg::CMD_SEED) begin
							angle_q <= tilt;
							bias_q <= 48'(gx_q) <<< 24;
							state_q <= ST_OUT;
						end else begin
							state_q <= ST_RATEL;
						end
					end
				end
				ST_RATEL: begin
					phase_q <= ~phase_q;
					if (phase_q) begin
						tmp_q <= (64'(mac_p) + 64'sd8388608) >>> 24;
						state_q <= ST_RATEH;
					end
				end
				ST_RATEH: begin
					phase_q <= ~phase_q;
					if (phase_q) begin
						tmp_q <= tmp_q + 64'(mac_p);
						state_q <= ST_STEP;
					end
				end
				ST_STEP: begin
					phase_q <= ~phase_q;
					if (phase_q) begin
						tmp_q <= 64'(angle_q) + 64'((64'(mac_p) + 64'sd32768) >>> 16);
						state_q <= ST_MIXA;
					end
				end
				ST_MIXA: begin
					phase_q <= ~phase_q;
					if (phase_q) begin
						tmp_q <= 64'(mac_p);
						state_q <= ST_MIXB;
					end
				end
				ST_MIXB: begin
					phase_q <= ~phase_q;
					if (phase_q) begin
						if (mix_r > 64'sd2147483647) angle_q <= 32'sh7fffffff;
						else if (mix_r < -64'sd2147483648) angle_q <= 32'sh80000000;
						else angle_q <= mix_r[31:0];
						state_q <= ST_BIASL;
					end
				end
				ST_BIASL: begin
					phase_q <= ~phase_q;
					if (phase_q) begin
						tmp_q <= (64'(mac_p) + 64'sd8388608) >>> 24;
						state_q <= ST_BIASH;
					end
				end
				ST_BIASH: begin
					phase_q <= ~phase_q;
					if (phase_q) begin
						bias_q <= bias_q + 48'(tmp_q + 64'(mac_p));
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!out_valid) begin
						out_valid <= 1'b1;
						if (ta_r > 41'sd23040) tilt_angle <= 16'sd23040;
						else if (ta_r < -41'sd23040) tilt_angle <= -16'sd23040;
						else tilt_angle <= ta_r[15:0];
						if (be_r > 25'sd32767) bias_estimate <= 16'sh7fff;
						else if (be_r < -25'sd32768) bias_estimate <= 16'sh8000;
						else bias_estimate <= be_r[15:0];
					end else if (!out_stall) begin
						out_valid <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

>>> sim/tilt_complementary_filter_test.sv
// ----------------------------------------------------------------------------
// tilt_complementary_filter_test: self-checking bench for the tilt filter
// Drives seed and update items with random gaps and output stalls, predicts
// the tilt angle and bias estimate, and compares every result in order.
// ----------------------------------------------------------------------------
`default_nettype none

class tilt_scoreboard;
	// predictor state and registers
	logic signed [31:0] angle_q16;
	logic signed [47:0] bias_q24;
	logic [15:0] period_q16, blend_q16, scale_q16, track_q24;
	logic [9:0]  window_lsb;
	logic signed [15:0] pending_tilt[$];
	logic signed [15:0] pending_bias[$];
	int errors;
	int matched;

	function new();
		angle_q16 = 0;
		bias_q24 = 0;
		period_q16 = 16'd655;
		blend_q16 = 16'd64881;
		scale_q16 = 16'd1001;
		track_q24 = 16'd8389;
		window_lsb = 10'd10;
		errors = 0;
		matched = 0;
	endfunction

	function void set_reg(logic [2:0] idx, logic [15:0] val);
		case (idx)
			tcf_pkg::REG_SAMPLE_PERIOD: period_q16 = val;
			tcf_pkg::REG_GYRO_BLEND:    blend_q16 = val;
			tcf_pkg::REG_RATE_SCALE:    scale_q16 = val;
			tcf_pkg::REG_BIAS_RATE:     track_q24 = val;
			tcf_pkg::REG_BIAS_WINDOW:   window_lsb = val[9:0];
			default: ;
		endcase
	endfunction

	// half-up rounding shift
	function longint rnd(longint v, int s);
		return (v + (longint'(1) << (s - 1))) >>> s;
	endfunction

	function longint clip(longint v, longint lo, longint hi);
		if (v < lo)
			return lo;
		if (v > hi)
			return hi;
		return v;
	endfunction

	function longint atan_step(int i);
		case (i)
			0: return 2949120;   1: return 1740967;  2: return 919879;
			3: return 466945;    4: return 234379;   5: return 117304;
			6: return 58666;     7: return 29335;    8: return 14668;
			9: return 7334;      10: return 3667;    11: return 1833;
			12: return 917;      13: return 458;     14: return 229;
			15: return 115;
			default: return 0;
		endcase
	endfunction

	// accelerometer tilt by vectoring CORDIC, 1/65536 degree
	function longint accel_tilt(longint ay, longint az);
		longint x, y, z, xs, ys;
		x = az * 16384;
		y = ay * 16384;
		z = 0;
		if (ay == 0 && az == 0)
			return 0;
		if (x < 0) begin
			z = (y >= 0) ? 180 * 65536 : -180 * 65536;
			x = -x;
			y = -y;
		end
		for (int i = 0; i < tcf_pkg::CordicSteps; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x = x + ys;
				y = y - xs;
				z += atan_step(i);
			end else begin
				x = x - ys;
				y = y + xs;
				z -= atan_step(i);
			end
		end
		return z;
	endfunction

	// note an accepted input item and queue its expected result
	function void note_item(logic cmd, logic signed [15:0] ay, logic signed [15:0] az,
			logic signed [15:0] gx);
		longint tilt, gx24, d, rate, stp, mix, win, corr, acc, bias;
		tilt = accel_tilt(ay, az);
		gx24 = longint'(gx) <<< 24;
		acc = angle_q16;
		bias = bias_q24;
		if (cmd == tcf_pkg::CMD_SEED) begin
			acc = tilt;
			bias = gx24;
		end else begin
			d = gx24 - bias;
			rate = rnd(d * longint'(scale_q16), 24);
			stp = rnd(rate * longint'(period_q16), 16);
			mix = (acc + stp) * longint'(blend_q16) + tilt * (65536 - longint'(blend_q16));
			acc = clip(rnd(mix, 16), -64'sd2147483648, 64'sd2147483647);
			win = longint'(window_lsb) <<< 24;
			corr = clip(gx24, bias - win, bias + win);
			corr = clip(corr, -(longint'(32768) <<< 24), longint'(32767) <<< 24);
			bias = bias + rnd((corr - bias) * longint'(track_q24), 24);
		end
		angle_q16 = acc;
		bias_q24 = bias;
		pending_tilt.push_back(16'(clip(rnd(acc, 9), -23040, 23040)));
		pending_bias.push_back(16'(clip(rnd(bias, 24), -32768, 32767)));
	endfunction

	function void check_result(logic signed [15:0] ta, logic signed [15:0] be);
		logic signed [15:0] et, eb;
		if (pending_tilt.size() == 0) begin
			$error("unexpected result tilt_angle=%0d bias_estimate=%0d", ta, be);
			errors++;
			return;
		end
		et = pending_tilt.pop_front();
		eb = pending_bias.pop_front();
		matched++;
		if (ta !== et) begin
			$error("tilt_angle expected %0d actual %0d", et, ta);
			errors++;
		end
		if (be !== eb) begin
			$error("bias_estimate expected %0d actual %0d", eb, be);
			errors++;
		end
	endfunction
endclass

module tilt_complementary_filter_test;
	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic command = 1'b0;
	logic signed [15:0] accel_y = '0, accel_z = '0, gyro_x = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [15:0] tilt_angle, bias_estimate;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int items_sent = 0;
	longint cycles = 0;
	tilt_scoreboard board = new();

	localparam longint CycleLimit = 600000;

	tilt_complementary_filter i_dut (.*);

	initial forever #6 clk = ~clk;

	// cycle counter and timeout
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CycleLimit) begin
			$display("simulation failed");
			$finish;
		end
	end

	// receiver: random stalls, checks at each accepted result
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			board.check_result(tilt_angle, bias_estimate);
		out_stall <= ($urandom_range(99) < recv_stall_pct);
	end

	task automatic write_reg(logic [2:0] idx, logic [15:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		board.set_reg(idx, val);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// valid stays high after acceptance until the next item, an idle or a drain
	task automatic send_item(logic cmd, logic signed [15:0] ay, logic signed [15:0] az,
			logic signed [15:0] gx);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		command <= cmd;
		accel_y <= ay;
		accel_z <= az;
		gyro_x <= gx;
		do @(posedge clk); while (in_stall);
		board.note_item(cmd, ay, az, gx);
		items_sent++;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (board.pending_tilt.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	// mostly plausible tilt samples around 1 g, some full-range noise
	task automatic random_items(int n);
		logic signed [15:0] ay, az, gx;
		int r;
		for (int k = 0; k < n; k++) begin
			r = $urandom_range(99);
			if (r < 60) begin
				ay = 16'($signed($urandom_range(32000)) - 16000);
				az = 16'($signed($urandom_range(32000)) - 16000);
				gx = 16'($signed($urandom_range(400)) - 200);
			end else begin
				ay = 16'($urandom);
				az = 16'($urandom);
				gx = 16'($urandom);
			end
			send_item(($urandom_range(49) == 0) ? tcf_pkg::CMD_SEED : tcf_pkg::CMD_UPDATE,
				ay, az, gx);
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: field extremes, both commands, axis and zero cases
		send_item(tcf_pkg::CMD_UPDATE, 0, 0, 0);
		send_item(tcf_pkg::CMD_SEED, 16000, 16000, 25);
		send_item(tcf_pkg::CMD_UPDATE, 16000, 16000, 30);
		send_item(tcf_pkg::CMD_UPDATE, 0, -16000, -100);
		send_item(tcf_pkg::CMD_UPDATE, -1, -16000, 0);
		send_item(tcf_pkg::CMD_UPDATE, 32767, 0, 32767);
		send_item(tcf_pkg::CMD_UPDATE, -32768, 0, -32768);
		send_item(tcf_pkg::CMD_UPDATE, 0, 32767, 5);
		send_item(tcf_pkg::CMD_UPDATE, -32768, -32768, 32767);
		send_item(tcf_pkg::CMD_UPDATE, 32767, -32768, -32768);
		send_item(tcf_pkg::CMD_SEED, 0, -32768, 32767);
		send_item(tcf_pkg::CMD_UPDATE, 0, -32768, -32768);
		send_item(tcf_pkg::CMD_SEED, -32768, 32767, -32768);
		send_item(tcf_pkg::CMD_UPDATE, 0, 0, 32767);
		drain();

		// register extremes with large steps to push saturation
		write_reg(tcf_pkg::REG_SAMPLE_PERIOD, 16'hFFFF);
		write_reg(tcf_pkg::REG_GYRO_BLEND, 16'hFFFF);
		write_reg(tcf_pkg::REG_RATE_SCALE, 16'hFFFF);
		write_reg(tcf_pkg::REG_BIAS_RATE, 16'hFFFF);
		write_reg(tcf_pkg::REG_BIAS_WINDOW, 16'h03FF);
		for (int k = 0; k < 8; k++)
			send_item(tcf_pkg::CMD_UPDATE, 0, 16000, (k < 4) ? 16'sd32767 : -16'sd32768);
		drain();
		write_reg(tcf_pkg::REG_SAMPLE_PERIOD, 16'd1);
		write_reg(tcf_pkg::REG_GYRO_BLEND, 16'd0);
		write_reg(tcf_pkg::REG_RATE_SCALE, 16'd1);
		write_reg(tcf_pkg::REG_BIAS_RATE, 16'd0);
		write_reg(tcf_pkg::REG_BIAS_WINDOW, 16'd0);
		random_items(60);
		drain();

		// random phases: receiver stalls more, then sender idles more, then none
		write_reg(tcf_pkg::REG_SAMPLE_PERIOD, 16'd655);
		write_reg(tcf_pkg::REG_GYRO_BLEND, 16'd64881);
		write_reg(tcf_pkg::REG_RATE_SCALE, 16'd1001);
		write_reg(tcf_pkg::REG_BIAS_RATE, 16'd8389);
		write_reg(tcf_pkg::REG_BIAS_WINDOW, 16'd10);
		send_idle_pct = 19;
		recv_stall_pct = 65;
		random_items(300);
		drain();
		for (int i = 0; i < 5; i++)
			write_reg(3'(i), 16'($urandom));
		send_idle_pct = 65;
		recv_stall_pct = 19;
		random_items(250);
		drain();
		write_reg(tcf_pkg::REG_SAMPLE_PERIOD, 16'($urandom_range(65535, 1)));
		write_reg(tcf_pkg::REG_GYRO_BLEND, 16'($urandom_range(65535, 60000)));
		write_reg(tcf_pkg::REG_RATE_SCALE, 16'($urandom_range(65535, 1)));
		write_reg(tcf_pkg::REG_BIAS_RATE, 16'($urandom));
		write_reg(tcf_pkg::REG_BIAS_WINDOW, 16'($urandom_range(1023)));
		send_idle_pct = 0;
		recv_stall_pct = 0;
		random_items(250);
		drain();

		$display("covered %0d items (seed and update), %0d results checked",
			items_sent, board.matched);
		$display("register sets: reset values, both extremes and random");
		if (board.errors == 0 && board.pending_tilt.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule

`default_nettype wire

>>> filelist.f
rtl/tcf_pkg.sv
rtl/tcf_cordic.sv
rtl/tcf_mac.sv
rtl/tilt_complementary_filter.sv
sim/tilt_complementary_filter_test.sv
